// ===== rtl/core/pvrop_pkg.sv =====
// Shared types and constants for the planar video RAM raster-op controller.
// No dependencies; used by the front, back and top-level modules.
package pvrop_pkg;

    // Fixed field widths
    localparam int unsigned OFFSET_W   = 14;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned NUM_PLANES = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HICOLOR     = 3'd0,
        CFG_WIDE_640    = 3'd1,
        CFG_WRITE_MODE  = 3'd2,
        CFG_WRITE_MASK  = 3'd3,
        CFG_READ_MASK   = 3'd4,
        CFG_READ_SEARCH = 3'd5,
        CFG_BANK_B      = 3'd6
    } cfg_idx_t;

    // Write modes (replace and pset each cover two codes)
    localparam logic [2:0] WM_SINGLE    = 3'd0;
    localparam logic [2:0] WM_EXOR      = 3'd1;
    localparam logic [2:0] WM_OR        = 3'd2;
    localparam logic [2:0] WM_RESET     = 3'd3;
    localparam logic [2:0] WM_REPLACE   = 3'd4;
    localparam logic [2:0] WM_REPLACE_1 = 3'd5;

    // Plane availability patterns
    localparam logic [NUM_PLANES-1:0] PLANES_ALL    = 4'hf;
    localparam logic [NUM_PLANES-1:0] PLANES_BANK_A = 4'h3;
    localparam logic [NUM_PLANES-1:0] PLANES_BANK_B = 4'hc;
    localparam logic [NUM_PLANES-1:0] PLANES_WIDE   = 4'h5;

    // Per-access control word, indexed by physical plane
    typedef struct packed {
        logic                  is_write;
        logic [2:0]            mode;
        logic [NUM_PLANES-1:0] hit;   // plane ANDed into the read result
        logic [NUM_PLANES-1:0] miss;  // plane ORed into the search reject mask
        logic [NUM_PLANES-1:0] wen;   // plane written
        logic [NUM_PLANES-1:0] wsel;  // plane selected by the write mask
    } ctl_t;

    localparam int unsigned CTL_W = $bits(ctl_t);

endpackage

// ===== rtl/core/pvrop_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; one instance per video plane.
module pvrop_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pvrop_front.sv =====
// Front end: configuration registers, address folding and per-plane classification.
// Depends on pvrop_pkg; produces one packed queue entry per accepted access.
module pvrop_front #(
    parameter int unsigned PLANE_DEPTH = 8192,
    localparam int unsigned AW = $clog2(PLANE_DEPTH),
    localparam int unsigned ENTRY_W = AW + pvrop_pkg::DATA_W + pvrop_pkg::CTL_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pvrop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvrop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             req_type,
    input  logic [pvrop_pkg::OFFSET_W-1:0]   window_offset,
    input  logic [pvrop_pkg::DATA_W-1:0]     write_byte,
    output logic [ENTRY_W-1:0]               entry
);

    localparam int unsigned MW = 20;

    logic                              hicolor_reg;
    logic                              wide_reg;
    logic [2:0]                        mode_reg;
    logic [pvrop_pkg::NUM_PLANES-1:0]  wmask_reg;
    logic [pvrop_pkg::NUM_PLANES-1:0]  rmask_reg;
    logic                              search_reg;
    logic                              bank_reg;

    logic [MW-1:0]                     rem;
    logic [AW-1:0]                     addr;
    logic [pvrop_pkg::NUM_PLANES-1:0]  avail;
    pvrop_pkg::ctl_t                   ctl;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hicolor_reg <= 1'b0;
            wide_reg    <= 1'b0;
            mode_reg    <= pvrop_pkg::WM_SINGLE;
            wmask_reg   <= 4'h1;
            rmask_reg   <= 4'h1;
            search_reg  <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pvrop_pkg::CFG_HICOLOR:     hicolor_reg <= cfg_data[0];
                pvrop_pkg::CFG_WIDE_640:    wide_reg    <= cfg_data[0];
                pvrop_pkg::CFG_WRITE_MODE:  mode_reg    <= cfg_data[2:0];
                pvrop_pkg::CFG_WRITE_MASK:  wmask_reg   <= cfg_data;
                pvrop_pkg::CFG_READ_MASK:   rmask_reg   <= cfg_data;
                pvrop_pkg::CFG_READ_SEARCH: search_reg  <= cfg_data[0];
                pvrop_pkg::CFG_BANK_B:      bank_reg    <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Plane address: offset (halved in wide mode) modulo the plane depth,
    // by conditional subtraction of depth*8, *4, *2, *1
    always_comb
    begin
        rem = wide_reg ? MW'(window_offset[pvrop_pkg::OFFSET_W-1:1]) : MW'(window_offset);
        for (int i = 3; i >= 0; i--)
        begin
            if (rem >= (MW'(PLANE_DEPTH) << i))
            begin
                rem = rem - (MW'(PLANE_DEPTH) << i);
            end
        end
    end

    assign addr = rem[AW-1:0];

    // Logical planes available for search and replace/pset
    assign avail = ((hicolor_reg ? pvrop_pkg::PLANES_ALL : 4'h0)
                    | (bank_reg ? pvrop_pkg::PLANES_BANK_B : pvrop_pkg::PLANES_BANK_A))
                   & (wide_reg ? pvrop_pkg::PLANES_WIDE : pvrop_pkg::PLANES_ALL);

    // Per physical plane roles; in wide mode odd offsets map logical I/III to II/IV
    always_comb
    begin
        logic [1:0] k;
        logic       active;
        ctl.is_write = req_type;
        ctl.mode     = mode_reg;
        for (int p = 0; p < 4; p++)
        begin
            k      = wide_reg ? (2'(p) & 2'b10) : 2'(p);
            active = !wide_reg || (2'(p) & 2'b01) == {1'b0, window_offset[0]};
            ctl.hit[p]  = active && rmask_reg[k] && (!search_reg || avail[k]);
            ctl.miss[p] = active && search_reg && avail[k] && !rmask_reg[k];
            ctl.wsel[p] = wmask_reg[k];
            ctl.wen[p]  = req_type && active && (mode_reg[2] ? avail[k] : wmask_reg[k]);
        end
    end

    assign entry = {addr, write_byte, ctl};

endmodule

// ===== rtl/core/pvrop_queue.sv =====
// Short FIFO between front and back ends.
// No package dependency; entry width and depth set by parameters.
module pvrop_queue #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full  = count_reg == (PW+1)'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pvrop_back.sv =====
// Back end: plane memories, read-then-execute sequencer and output register.
// Depends on pvrop_pkg and pvrop_ram.
module pvrop_back #(
    parameter int unsigned PLANE_DEPTH = 8192,
    localparam int unsigned AW = $clog2(PLANE_DEPTH),
    localparam int unsigned ENTRY_W = AW + pvrop_pkg::DATA_W + pvrop_pkg::CTL_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic [ENTRY_W-1:0]           q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pvrop_pkg::DATA_W-1:0] m_tdata
);

    localparam int unsigned CW = pvrop_pkg::CTL_W;
    localparam int unsigned DW = pvrop_pkg::DATA_W;

    typedef enum logic {
        S_ISSUE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [DW-1:0]       out_data_reg;
    logic [ENTRY_W-1:0]  cur_reg;

    pvrop_pkg::ctl_t     ctl;
    logic [DW-1:0]       cur_data;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       ram_addr;
    logic [DW-1:0]       rdata [pvrop_pkg::NUM_PLANES];
    logic [DW-1:0]       wdata [pvrop_pkg::NUM_PLANES];
    logic [pvrop_pkg::NUM_PLANES-1:0] we;
    logic [DW-1:0]       result;
    logic                exec_go;

    assign ctl      = pvrop_pkg::ctl_t'(cur_reg[CW-1:0]);
    assign cur_data = cur_reg[CW +: DW];
    assign cur_addr = cur_reg[CW+DW +: AW];

    // Take the next access only when the sequencer is ready for it
    assign q_pop    = (state_reg == S_ISSUE) && q_valid;
    assign ram_addr = (state_reg == S_ISSUE) ? q_head[CW+DW +: AW] : cur_addr;

    // A read result waits while the output register still holds an untaken transfer
    assign exec_go  = (state_reg == S_EXEC) && (ctl.is_write || !out_valid_reg || m_tready);

    // Plane memories
    for (genvar p = 0; p < pvrop_pkg::NUM_PLANES; p++)
    begin : g_plane
        pvrop_ram #(
            .WIDTH (DW),
            .DEPTH (PLANE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we[p]),
            .re    (q_pop),
            .addr  (ram_addr),
            .wdata (wdata[p]),
            .rdata (rdata[p])
        );
    end

    // Read combine: AND of hit planes, masked by OR of miss planes
    always_comb
    begin
        logic [DW-1:0] hit_acc;
        logic [DW-1:0] miss_acc;
        hit_acc  = '1;
        miss_acc = '0;
        for (int p = 0; p < 4; p++)
        begin
            if (ctl.hit[p])
            begin
                hit_acc = hit_acc & rdata[p];
            end
            if (ctl.miss[p])
            begin
                miss_acc = miss_acc | rdata[p];
            end
        end
        result = hit_acc & ~miss_acc;
    end

    // Raster operation per plane
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            we[p] = exec_go && ctl.is_write && ctl.wen[p];
            case (ctl.mode) inside
                pvrop_pkg::WM_SINGLE: wdata[p] = cur_data;
                pvrop_pkg::WM_EXOR:   wdata[p] = cur_data ^ rdata[p];
                pvrop_pkg::WM_OR:     wdata[p] = cur_data | rdata[p];
                pvrop_pkg::WM_RESET:  wdata[p] = ~cur_data & rdata[p];
                [pvrop_pkg::WM_REPLACE:pvrop_pkg::WM_REPLACE_1]:
                    wdata[p] = ctl.wsel[p] ? cur_data : '0;
                default:
                    wdata[p] = ctl.wsel[p] ? (cur_data | rdata[p]) : (~cur_data & rdata[p]);
            endcase
        end
    end

    // Sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ISSUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_ISSUE:
                begin
                    if (q_pop)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg <= S_ISSUE;
                    end
                end
                default: state_reg <= S_ISSUE;
            endcase
            if (exec_go && !ctl.is_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (exec_go && !ctl.is_write)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/planar_vram_raster_op_controller.sv =====
// Top level of the planar video RAM raster-op controller.
// Depends on pvrop_pkg, pvrop_front, pvrop_queue and pvrop_back.
//
//   Channel   Direction  Transfer when          Contents
//   s_axis    in         s_tvalid & s_tready    tuser: req_type; tdata: offset, byte
//   m_axis    out        m_tvalid & m_tready    tdata: read_byte (reads only)
//   cfg       in         cfg_we                 register cfg_index <= cfg_data
//
// The back end handles each access in order: it first reads all four plane RAMs at the
// folded address, then combines the data and writes planes or loads the result.
// The front takes a transfer every cycle while the two-entry queue has room.
// Reset clears control state only; plane contents are undefined until written.
// A read result held in the output register stalls the back end; the front keeps
// taking transfers until the queue is full, then holds s_tready low.
module planar_vram_raster_op_controller #(
    parameter int unsigned PLANE_DEPTH = 8192
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pvrop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvrop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,  // [13:0] window_offset, [21:14] write_byte
    input  logic [0:0]                       s_tuser,  // [0] req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata   // [7:0] read_byte
);

    localparam int unsigned AW      = $clog2(PLANE_DEPTH);
    localparam int unsigned ENTRY_W = AW + pvrop_pkg::DATA_W + pvrop_pkg::CTL_W;

    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] q_head;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Front: classify the access
    pvrop_front #(
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (s_tuser[0]),
        .window_offset (s_tdata[13:0]),
        .write_byte    (s_tdata[21:14]),
        .entry         (entry)
    );

    // Queue between front and back
    pvrop_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back: plane access and raster operation
    pvrop_back #(
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
